// File: src/cfq_pkg.sv
// ----------------------------------------------------------------------------
// Circular FIFO queue package
// Shared types, codes and constants of the circular FIFO queue.
// ----------------------------------------------------------------------------
`default_nettype none

package cfq_pkg;

  localparam int unsigned MAX_DEPTH_DEF = 64;
  localparam int unsigned DATA_W        = 32;
  localparam int unsigned CAP_W         = 7;
  localparam int unsigned OP_W          = 2;
  localparam int unsigned STATUS_W      = 2;
  localparam int unsigned OUT_TDATA_W   = 40;

  typedef enum logic [OP_W-1:0] {
    OP_ENQUEUE = 2'd0,
    OP_DEQUEUE = 2'd1,
    OP_PEEK    = 2'd2,
    OP_DISPLAY = 2'd3
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_LOAD = 2'd1,
    S_SEND = 2'd2
  } state_e;

  typedef struct packed {
    logic accept;
    logic load;
    logic next;
  } cmd_t;

  typedef struct packed {
    logic more;
  } sts_t;

endpackage

`default_nettype wire

// File: src/cfq_ctrl.sv
// ----------------------------------------------------------------------------
// Circular FIFO queue controller
// Sequences accept, result load and result transfer for one item at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module cfq_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  input  wire cfq_pkg::sts_t sts_i,
  output cfq_pkg::cmd_t      cmd_o
);

  cfq_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cfq_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    cmd_o       = '0;
    case (state_q)
      cfq_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = cfq_pkg::S_LOAD;
        end
      end
      cfq_pkg::S_LOAD: begin
        cmd_o.load = 1'b1;
        state_d    = cfq_pkg::S_SEND;
      end
      cfq_pkg::S_SEND: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          if (sts_i.more) begin
            cmd_o.next = 1'b1;
            state_d    = cfq_pkg::S_LOAD;
          end else begin
            state_d = cfq_pkg::S_IDLE;
          end
        end
      end
      default: begin
        state_d = cfq_pkg::S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: src/cfq_dp.sv
// ----------------------------------------------------------------------------
// Circular FIFO queue datapath
// Slot memory, head and tail pointers, capacity and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module cfq_dp #(
  parameter int unsigned MAX_DEPTH = cfq_pkg::MAX_DEPTH_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [cfq_pkg::CAP_W-1:0]     cfg_wdata_i,
  input  wire logic [cfq_pkg::OP_W-1:0]      in_op_i,
  input  wire logic [cfq_pkg::DATA_W-1:0]    in_value_i,
  input  wire cfq_pkg::cmd_t                 cmd_i,
  output cfq_pkg::sts_t                      sts_o,
  output logic [cfq_pkg::DATA_W-1:0]         out_data_o,
  output logic [cfq_pkg::STATUS_W-1:0]       out_status_o,
  output logic                               out_last_o,
  output logic                               out_empty_o,
  output logic                               out_full_o
);

  localparam int unsigned AW = $clog2(MAX_DEPTH);
  localparam int unsigned CW = $clog2(MAX_DEPTH + 1);
  localparam int unsigned IW = AW + 1;

  logic [cfq_pkg::DATA_W-1:0] mem [MAX_DEPTH];
  logic [cfq_pkg::DATA_W-1:0] rdata_q;

  logic [AW-1:0] head_q, head_d;
  logic [AW-1:0] tail_q, tail_d;
  logic          empty_q, empty_d;
  logic [CW-1:0] cap_q, cap_d;
  logic [AW-1:0] idx_q, idx_d;
  logic [CW-1:0] cnt_q, cnt_d;

  cfq_pkg::status_e status_q, status_d;
  logic             use_rd_q, use_rd_d;
  logic             disp_q, disp_d;

  logic [cfq_pkg::DATA_W-1:0]   out_data_q;
  cfq_pkg::status_e             out_status_q;
  logic                         out_last_q;
  logic                         out_empty_q;
  logic                         out_full_q;

  logic          full;
  logic          fin;
  logic          mem_we;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] tail_adv;
  logic [AW-1:0] idx_adv;
  cfq_pkg::op_e  op;

  function automatic logic [AW-1:0] adv(input logic [AW-1:0] idx, input logic [CW-1:0] cap);
    logic [IW-1:0] nxt;
    nxt = IW'(idx) + IW'(1);
    if (nxt >= IW'(cap)) begin
      return '0;
    end
    return nxt[AW-1:0];
  endfunction

  assign op       = cfq_pkg::op_e'(in_op_i);
  assign tail_adv = adv(tail_q, cap_q);
  assign idx_adv  = cmd_i.next ? adv(idx_q, cap_q) : adv(head_q, cap_q);

  assign full = !empty_q &&
                (((head_q == '0) && (IW'(tail_q) == IW'(cap_q) - IW'(1))) ||
                 (IW'(head_q) == IW'(tail_q) + IW'(1)));

  assign fin = (idx_q == tail_q) || ((CW + 1)'(cnt_q) + (CW + 1)'(1) >= (CW + 1)'(cap_q));

  always_comb begin
    head_d   = head_q;
    tail_d   = tail_q;
    empty_d  = empty_q;
    cap_d    = cap_q;
    idx_d    = idx_q;
    cnt_d    = cnt_q;
    status_d = status_q;
    use_rd_d = use_rd_q;
    disp_d   = disp_q;
    mem_we   = 1'b0;
    wr_addr  = empty_q ? '0 : tail_adv;
    rd_addr  = cmd_i.next ? idx_adv : head_q;
    if (cfg_we_i) begin
      if (cfg_wdata_i == '0) begin
        cap_d = CW'(1);
      end else if (cfg_wdata_i > cfq_pkg::CAP_W'(MAX_DEPTH)) begin
        cap_d = CW'(MAX_DEPTH);
      end else begin
        cap_d = CW'(cfg_wdata_i);
      end
      head_d  = '0;
      tail_d  = '0;
      empty_d = 1'b1;
    end else if (cmd_i.accept) begin
      status_d = cfq_pkg::ST_OK;
      use_rd_d = 1'b0;
      disp_d   = 1'b0;
      idx_d    = head_q;
      cnt_d    = '0;
      case (op)
        cfq_pkg::OP_ENQUEUE: begin
          if (full) begin
            status_d = cfq_pkg::ST_OVERFLOW;
          end else begin
            mem_we  = 1'b1;
            tail_d  = wr_addr;
            empty_d = 1'b0;
            if (empty_q) begin
              head_d = '0;
            end
          end
        end
        cfq_pkg::OP_DEQUEUE: begin
          if (empty_q) begin
            status_d = cfq_pkg::ST_UNDERFLOW;
          end else begin
            use_rd_d = 1'b1;
            if (head_q == tail_q) begin
              head_d  = '0;
              tail_d  = '0;
              empty_d = 1'b1;
            end else begin
              head_d = idx_adv;
            end
          end
        end
        cfq_pkg::OP_PEEK: begin
          if (empty_q) begin
            status_d = cfq_pkg::ST_UNDERFLOW;
          end else begin
            use_rd_d = 1'b1;
          end
        end
        cfq_pkg::OP_DISPLAY: begin
          if (empty_q) begin
            status_d = cfq_pkg::ST_UNDERFLOW;
          end else begin
            use_rd_d = 1'b1;
            disp_d   = 1'b1;
          end
        end
        default: begin
          status_d = cfq_pkg::ST_UNDERFLOW;
        end
      endcase
    end else if (cmd_i.next) begin
      idx_d = idx_adv;
      cnt_d = cnt_q + CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[wr_addr] <= in_value_i;
    end
    rdata_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q   <= '0;
      tail_q   <= '0;
      empty_q  <= 1'b1;
      cap_q    <= CW'(MAX_DEPTH);
      disp_q   <= 1'b0;
      use_rd_q <= 1'b0;
      status_q <= cfq_pkg::ST_OK;
      idx_q    <= '0;
      cnt_q    <= '0;
    end else begin
      head_q   <= head_d;
      tail_q   <= tail_d;
      empty_q  <= empty_d;
      cap_q    <= cap_d;
      disp_q   <= disp_d;
      use_rd_q <= use_rd_d;
      status_q <= status_d;
      idx_q    <= idx_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      out_data_q   <= use_rd_q ? rdata_q : '0;
      out_status_q <= status_q;
      out_last_q   <= disp_q ? fin : 1'b1;
      out_empty_q  <= empty_q;
      out_full_q   <= full;
    end
  end

  assign sts_o.more   = disp_q && !out_last_q;
  assign out_data_o   = out_data_q;
  assign out_status_o = out_status_q;
  assign out_last_o   = out_last_q;
  assign out_empty_o  = out_empty_q;
  assign out_full_o   = out_full_q;

  a_ptr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (IW'(head_q) < IW'(cap_q)) && (IW'(tail_q) < IW'(cap_q)))
    else $error("Head or tail pointer beyond the configured capacity.");

  a_enq_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.accept && !cfg_we_i && (op == cfq_pkg::OP_ENQUEUE) && !full) |=> !empty_q)
    else $error("Queue still empty after a stored enqueue.");

  a_deq_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.accept && !cfg_we_i && (op == cfq_pkg::OP_DEQUEUE) && !empty_q &&
     (head_q == tail_q)) |=> empty_q)
    else $error("Queue not empty after removing its only word.");

  a_disp_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.load && disp_q) |-> (cnt_q < cap_q))
    else $error("Display ran past the configured capacity.");

endmodule

`default_nettype wire

// File: src/circular_fifo_queue.sv
// ----------------------------------------------------------------------------
// Circular FIFO queue
// Capacity-limited circular queue of signed 32-bit words with enqueue,
// dequeue, peek and display operations over a stream interface.
// ----------------------------------------------------------------------------
// Items are handled one at a time. An enqueue, dequeue or peek passes
// through the input transfer, in which the slot memory is read into a
// register, a load of the result register, and the offer of the result, and
// the input side takes no new item until that result has been taken. A
// display of N stored words produces N results, each needing a memory read
// and a result load, and the input side waits until the last is taken.
// Writing the capacity register empties the queue; a value of zero acts as
// one and a value above MAX_DEPTH acts as MAX_DEPTH.
`default_nettype none

module circular_fifo_queue #(
  parameter int unsigned MAX_DEPTH = cfq_pkg::MAX_DEPTH_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [cfq_pkg::CAP_W-1:0]         cfg_wdata_i,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // Bits 31:0 value.
  input  wire logic [cfq_pkg::DATA_W-1:0]        s_axis_tdata,
  // Bits 1:0 op.
  input  wire logic [cfq_pkg::OP_W-1:0]          s_axis_tuser,
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // Bits 31:0 data, bit 32 is_empty, bit 33 is_full, upper bits zero.
  output logic [cfq_pkg::OUT_TDATA_W-1:0]        m_axis_tdata,
  // Bits 1:0 status.
  output logic [cfq_pkg::STATUS_W-1:0]           m_axis_tuser,
  output logic                                   m_axis_tlast
);

  cfq_pkg::cmd_t              cmd;
  cfq_pkg::sts_t              sts;
  logic [cfq_pkg::DATA_W-1:0] out_data;
  logic                       out_empty;
  logic                       out_full;

  cfq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  cfq_dp #(
    .MAX_DEPTH (MAX_DEPTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_op_i      (s_axis_tuser),
    .in_value_i   (s_axis_tdata),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_data_o   (out_data),
    .out_status_o (m_axis_tuser),
    .out_last_o   (m_axis_tlast),
    .out_empty_o  (out_empty),
    .out_full_o   (out_full)
  );

  assign m_axis_tdata = {6'b0, out_full, out_empty, out_data};

endmodule

`default_nettype wire

// File: tb/circular_fifo_queue_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Circular FIFO queue testbench
// Drives enqueue, dequeue, peek and display commands into the queue and
// compares every result transfer with a behavioural model of the queue that
// is kept inside the bench. A directed opening covers the empty and full
// cases, the range extremes of the data and the capacity register. Random
// phases with several capacities and idling patterns follow.
// ----------------------------------------------------------------------------

module circular_fifo_queue_tb;

  localparam int unsigned QDEPTH = cfq_pkg::MAX_DEPTH_DEF;

  typedef struct packed {
    cfq_pkg::op_e                  op;
    logic [cfq_pkg::DATA_W-1:0]    value;
  } fifo_cmd_t;

  typedef struct packed {
    logic [cfq_pkg::DATA_W-1:0]    data;
    cfq_pkg::status_e              status;
    logic                          last;
    logic                          empty;
    logic                          full;
  } fifo_resp_t;

  logic                            clk_i         = 1'b0;
  logic                            rst_ni        = 1'b0;
  logic                            cfg_we_i      = 1'b0;
  logic [cfq_pkg::CAP_W-1:0]       cfg_wdata_i   = '0;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [cfq_pkg::DATA_W-1:0]      s_axis_tdata  = '0;
  logic [cfq_pkg::OP_W-1:0]        s_axis_tuser  = cfq_pkg::OP_ENQUEUE;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  logic [cfq_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
  logic [cfq_pkg::STATUS_W-1:0]    m_axis_tuser;
  logic                            m_axis_tlast;

  circular_fifo_queue u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  fifo_cmd_t   cmd_backlog[$];
  fifo_resp_t  queued_results[$];
  fifo_cmd_t   cmd_on_bus;

  logic [cfq_pkg::DATA_W-1:0] fifo_mem [QDEPTH];
  int unsigned                fifo_head;
  int unsigned                fifo_tail;
  int unsigned                fifo_cap;
  bit                         fifo_empty;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;

  int unsigned fail_count      = 0;
  int unsigned cmds_sent       = 0;
  int unsigned results_seen    = 0;
  int unsigned overflow_seen   = 0;
  int unsigned underflow_seen  = 0;
  int unsigned longest_listing = 0;
  int unsigned cap_writes      = 0;

  function automatic int unsigned cap_in_use();
    if (fifo_cap == 0) return 1;
    if (fifo_cap > QDEPTH) return QDEPTH;
    return fifo_cap;
  endfunction

  function automatic int unsigned step_index(int unsigned idx);
    return (idx + 1 >= cap_in_use()) ? 0 : idx + 1;
  endfunction

  function automatic bit fifo_full();
    if (fifo_empty) return 1'b0;
    return (fifo_head == 0 && fifo_tail == cap_in_use() - 1) || (fifo_head == fifo_tail + 1);
  endfunction

  function automatic void fifo_clear();
    fifo_head  = 0;
    fifo_tail  = 0;
    fifo_empty = 1'b1;
  endfunction

  function automatic void post_result(logic [cfq_pkg::DATA_W-1:0] d, cfq_pkg::status_e st,
                                      bit lst);
    fifo_resp_t r;
    r.data   = d;
    r.status = st;
    r.last   = lst;
    r.empty  = fifo_empty;
    r.full   = fifo_full();
    queued_results.push_back(r);
  endfunction

  function automatic void fifo_apply_op(fifo_cmd_t c);
    int unsigned                idx;
    int unsigned                n;
    bit                         fin;
    logic [cfq_pkg::DATA_W-1:0] d;
    case (c.op)
      cfq_pkg::OP_ENQUEUE: begin
        if (fifo_full()) begin
          post_result('0, cfq_pkg::ST_OVERFLOW, 1'b1);
        end else begin
          if (fifo_empty) begin
            fifo_head  = 0;
            fifo_tail  = 0;
            fifo_empty = 1'b0;
          end else begin
            fifo_tail = step_index(fifo_tail);
          end
          fifo_mem[fifo_tail] = c.value;
          post_result('0, cfq_pkg::ST_OK, 1'b1);
        end
      end
      cfq_pkg::OP_DEQUEUE: begin
        if (fifo_empty) begin
          post_result('0, cfq_pkg::ST_UNDERFLOW, 1'b1);
        end else begin
          d = fifo_mem[fifo_head];
          if (fifo_head == fifo_tail) fifo_clear();
          else fifo_head = step_index(fifo_head);
          post_result(d, cfq_pkg::ST_OK, 1'b1);
        end
      end
      cfq_pkg::OP_PEEK: begin
        if (fifo_empty) post_result('0, cfq_pkg::ST_UNDERFLOW, 1'b1);
        else post_result(fifo_mem[fifo_head], cfq_pkg::ST_OK, 1'b1);
      end
      default: begin
        if (fifo_empty) begin
          post_result('0, cfq_pkg::ST_UNDERFLOW, 1'b1);
        end else begin
          idx = fifo_head;
          n   = 0;
          do begin
            fin = (idx == fifo_tail) || (n + 1 >= cap_in_use());
            post_result(fifo_mem[idx], cfq_pkg::ST_OK, fin);
            n++;
            idx = step_index(idx);
          end while (!fin);
          if (n > longest_listing) longest_listing = n;
        end
      end
    endcase
  endfunction

  function automatic void note_failure(string msg);
    fail_count++;
    if (fail_count <= 10) $display("ERROR at %0t: %s", $realtime, msg);
  endfunction

  // Input side: a new command is offered whenever the previous one has been
  // taken, unless the sender chooses to idle in this cycle.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        fifo_apply_op(cmd_on_bus);
        cmds_sent++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (cmd_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          cmd_on_bus = cmd_backlog.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= cmd_on_bus.value;
          s_axis_tuser  <= cmd_on_bus.op;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Output side: every result transfer is checked against the oldest
  // prediction.
  always @(posedge clk_i or negedge rst_ni) begin
    fifo_resp_t got;
    fifo_resp_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.data   = m_axis_tdata[cfq_pkg::DATA_W-1:0];
        got.empty  = m_axis_tdata[32];
        got.full   = m_axis_tdata[33];
        got.status = cfq_pkg::status_e'(m_axis_tuser);
        got.last   = m_axis_tlast;
        results_seen++;
        if (got.status == cfq_pkg::ST_OVERFLOW) overflow_seen++;
        if (got.status == cfq_pkg::ST_UNDERFLOW) underflow_seen++;
        if (queued_results.size() == 0) begin
          note_failure($sformatf("unexpected result data %h status %0d last %b",
                                 got.data, got.status, got.last));
        end else begin
          want = queued_results.pop_front();
          if (got !== want || m_axis_tdata[cfq_pkg::OUT_TDATA_W-1:34] !== '0) begin
            note_failure($sformatf({"result %0d: expected data %h st %0d last %b ",
                                    "empty %b full %b, got data %h st %0d last %b ",
                                    "empty %b full %b pad %h"},
              results_seen, want.data, want.status, want.last, want.empty, want.full,
              got.data, got.status, got.last, got.empty, got.full,
              m_axis_tdata[cfq_pkg::OUT_TDATA_W-1:34]));
          end
        end
      end
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic push_cmd(cfq_pkg::op_e op, logic [cfq_pkg::DATA_W-1:0] value);
    fifo_cmd_t c;
    c.op    = op;
    c.value = value;
    cmd_backlog.push_back(c);
  endtask

  task automatic queue_random(int unsigned n, int unsigned enq_pct);
    int unsigned  r;
    cfq_pkg::op_e op;
    repeat (n) begin
      r = $urandom_range(99);
      if (r < enq_pct) op = cfq_pkg::OP_ENQUEUE;
      else if (r < enq_pct + (100 - enq_pct) / 2) op = cfq_pkg::OP_DEQUEUE;
      else if (r < enq_pct + 3 * (100 - enq_pct) / 4) op = cfq_pkg::OP_PEEK;
      else op = cfq_pkg::OP_DISPLAY;
      push_cmd(op, $urandom);
    end
  endtask

  task automatic wait_idle();
    while (cmd_backlog.size() != 0 || s_axis_tvalid || queued_results.size() != 0)
      @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  // The register write also empties the queue, so the model is cleared with it.
  task automatic write_capacity(logic [cfq_pkg::CAP_W-1:0] v);
    wait_idle();
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    fifo_cap = v;
    fifo_clear();
    cap_writes++;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_idling(int unsigned send_pct, int unsigned stall_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = stall_pct;
  endtask

  initial begin
    fifo_cap = QDEPTH;
    fifo_clear();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    push_cmd(cfq_pkg::OP_DEQUEUE, 32'h0);
    push_cmd(cfq_pkg::OP_DISPLAY, 32'h0);
    push_cmd(cfq_pkg::OP_ENQUEUE, 32'h1234_5678);
    push_cmd(cfq_pkg::OP_DISPLAY, 32'h0);
    push_cmd(cfq_pkg::OP_DEQUEUE, 32'h0);

    write_capacity(7'd2);
    push_cmd(cfq_pkg::OP_PEEK,    32'hFFFF_FFFF);
    push_cmd(cfq_pkg::OP_ENQUEUE, 32'h7FFF_FFFF);
    push_cmd(cfq_pkg::OP_ENQUEUE, 32'h8000_0000);
    push_cmd(cfq_pkg::OP_ENQUEUE, 32'hFFFF_FFFF);
    push_cmd(cfq_pkg::OP_PEEK,    32'h0);
    push_cmd(cfq_pkg::OP_DISPLAY, 32'h0);
    push_cmd(cfq_pkg::OP_DEQUEUE, 32'h0);
    push_cmd(cfq_pkg::OP_ENQUEUE, 32'h0000_0000);
    push_cmd(cfq_pkg::OP_DEQUEUE, 32'h0);
    push_cmd(cfq_pkg::OP_ENQUEUE, 32'hFFFF_FFFF);
    push_cmd(cfq_pkg::OP_DISPLAY, 32'h0);
    push_cmd(cfq_pkg::OP_DEQUEUE, 32'h0);
    push_cmd(cfq_pkg::OP_DEQUEUE, 32'h0);
    push_cmd(cfq_pkg::OP_DISPLAY, 32'h0);

    write_capacity(7'd0);
    push_cmd(cfq_pkg::OP_ENQUEUE, 32'hAAAA_5555);
    push_cmd(cfq_pkg::OP_ENQUEUE, 32'h5555_AAAA);
    push_cmd(cfq_pkg::OP_DISPLAY, 32'h0);
    push_cmd(cfq_pkg::OP_DEQUEUE, 32'h0);

    // Capacity above the built depth: fill completely, overflow, list it all.
    write_capacity(7'd127);
    repeat (66) push_cmd(cfq_pkg::OP_ENQUEUE, $urandom);
    push_cmd(cfq_pkg::OP_DISPLAY, $urandom);
    queue_random(10, 30);

    write_capacity(7'd3);
    set_idling(51, 0);
    queue_random(30, 45);

    write_capacity(7'd1);
    set_idling(0, 51);
    queue_random(20, 45);

    write_capacity(7'($urandom_range(4, 12)));
    set_idling(35, 35);
    queue_random(30, 50);

    write_capacity(7'd64);
    set_idling(51, 0);
    queue_random(25, 60);

    wait_idle();
    if (queued_results.size() != 0)
      note_failure($sformatf("%0d results never arrived", queued_results.size()));

    $display("Covered %0d commands and %0d result transfers over %0d capacity settings.",
             cmds_sent, results_seen, cap_writes);
    $display("Overflows %0d, underflows %0d, longest listing %0d words; failures %0d.",
             overflow_seen, underflow_seen, longest_listing, fail_count);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timed out with %0d commands and %0d results outstanding.",
             cmd_backlog.size(), queued_results.size());
    $display("TEST FAILED");
    $finish;
  end

endmodule
